// ===== design/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants for the atlas rectangle placer
// Status codes, field widths, controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package arp_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int SIZE_W          = 15;
    localparam int POS_W           = 14;
    localparam logic [SIZE_W-1:0] ATLAS_LIMIT = 15'd16384;
    localparam logic [SIZE_W-1:0] ATLAS_RESET = 15'd4096;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2,
        ST_TOO_BIG  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // latch request, clear candidate
        logic rd_entry;    // issue stored-rect read at scan index
        logic chk_entry;   // compare registered entry with candidate
        logic next_entry;  // advance scan index
        logic jump_x;      // move x past the hit rectangle
        logic next_row;    // x to 0, y += step_y
        logic store;       // write candidate into table
        logic first;       // first rectangle: steps become its size
        logic gcd_start;   // start both gcd units
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic too_big;
        logic full;
        logic empty;
        logic entries_done; // scan index reached count
        logic hit;          // registered entry overlaps candidate
        logic x_over;       // x beyond max_x
        logic y_over;       // y beyond max_y
        logic jump_busy;    // x jump in progress
        logic gcd_busy;
    } dp_sts_t;

endpackage

// ===== design/arp_gcd.sv =====
// ----------------------------------------------------------------------------
// arp_gcd: iterative gcd unit
// Subtract-and-swap with one subtraction or swap per cycle while busy.
// ----------------------------------------------------------------------------
module arp_gcd (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [arp_pkg::SIZE_W-1:0] a,
    input  logic [arp_pkg::SIZE_W-1:0] b,
    output logic                      busy,
    output logic [arp_pkg::SIZE_W-1:0] result
);
    logic [arp_pkg::SIZE_W-1:0] a_reg, b_reg;
    logic busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (a_reg >= b_reg)
            begin
                a_reg <= b_reg;
                b_reg <= a_reg - b_reg;
            end
            else
            begin
                a_reg <= b_reg;
                b_reg <= a_reg;
            end
        end
    end

    assign busy   = busy_reg;
    assign result = (a_reg == '0) ? {{(arp_pkg::SIZE_W-1){1'b0}}, 1'b1} : a_reg;
endmodule

// ===== design/arp_datapath.sv =====
// ----------------------------------------------------------------------------
// arp_datapath: candidate position, rectangle table and step registers
// Holds the stored rectangles in a memory and checks them one at a time.
// ----------------------------------------------------------------------------
module arp_datapath #(
    parameter int MAX_ENTRIES = arp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [arp_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic [arp_pkg::SIZE_W-1:0] rect_width,
    input  logic [arp_pkg::SIZE_W-1:0] rect_height,
    input  arp_pkg::dp_cmd_t           cmd,
    output arp_pkg::dp_sts_t           sts,
    output logic [arp_pkg::POS_W-1:0]  cand_x,
    output logic [arp_pkg::POS_W-1:0]  cand_y
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SW    = arp_pkg::SIZE_W;
    localparam int PW    = arp_pkg::POS_W;
    localparam int EW    = 2 * PW + 2 * SW;

    logic [SW-1:0] atlas_reg;
    logic [SW-1:0] w_reg, h_reg, eff_reg;
    logic [SW-1:0] step_x_reg, step_y_reg;
    logic [SW-1:0] step_x_next, step_y_next;
    logic [CNT_W-1:0] count_reg, idx_reg;
    logic [SW:0] x_reg, y_reg;          // one spare bit so stepping past max shows
    logic [EW-1:0] mem [MAX_ENTRIES];
    logic [EW-1:0] ent_reg;
    logic hit_reg;
    logic [SW:0] edge_reg;
    logic jump_busy_reg;
    logic g_pend_reg;
    logic gcd_done;

    logic [SW-1:0] eff_size;
    logic [PW-1:0] ex, ey;
    logic [SW-1:0] ew, eh;
    logic [SW:0] ex_end, ey_end, cx_end, cy_end;
    logic overlap;
    logic gx_busy, gy_busy;
    logic [SW-1:0] gx_res, gy_res;

    assign eff_size = (atlas_reg > arp_pkg::ATLAS_LIMIT) ? arp_pkg::ATLAS_LIMIT : atlas_reg;
    assign {ex, ey, ew, eh} = ent_reg;
    assign ex_end = {2'b0, ex} + {1'b0, ew};
    assign ey_end = {2'b0, ey} + {1'b0, eh};
    assign cx_end = x_reg + {1'b0, w_reg};
    assign cy_end = y_reg + {1'b0, h_reg};
    assign overlap = (x_reg < ex_end) && ({2'b0, ex} < cx_end)
                  && (y_reg < ey_end) && ({2'b0, ey} < cy_end);

    // gcd results fold back into the steps once both units finish
    assign gcd_done = g_pend_reg && !gx_busy && !gy_busy;

    always_comb
    begin
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        if (gcd_done)
        begin
            step_x_next = gx_res;
            step_y_next = gy_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_reg     <= arp_pkg::ATLAS_RESET;
            count_reg     <= '0;
            step_x_reg    <= {{(SW-1){1'b0}}, 1'b1};
            step_y_reg    <= {{(SW-1){1'b0}}, 1'b1};
            jump_busy_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                atlas_reg <= cfg_wdata;
            end
            if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.first)
            begin
                step_x_reg <= w_reg;
                step_y_reg <= h_reg;
            end
            else
            begin
                step_x_reg <= step_x_next;
                step_y_reg <= step_y_next;
            end
            if (cmd.jump_x)
            begin
                jump_busy_reg <= 1'b1;
            end
            else if (jump_busy_reg && (x_reg >= edge_reg || x_reg > {1'b0, eff_reg - w_reg}))
            begin
                jump_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_pend_reg <= 1'b0;
        end
        else if (cmd.gcd_start)
        begin
            g_pend_reg <= 1'b1;
        end
        else if (gcd_done)
        begin
            g_pend_reg <= 1'b0;
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg   <= rect_width;
            h_reg   <= rect_height;
            eff_reg <= eff_size;
            x_reg   <= '0;
            y_reg   <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.next_entry)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.jump_x)
            begin
                edge_reg <= ex_end;
                idx_reg  <= '0;
            end
            else if (jump_busy_reg && !(x_reg >= edge_reg || x_reg > {1'b0, eff_reg - w_reg}))
            begin
                x_reg <= x_reg + {1'b0, step_x_reg};
            end
            if (cmd.next_row)
            begin
                x_reg   <= '0;
                y_reg   <= y_reg + {1'b0, step_y_reg};
                idx_reg <= '0;
            end
        end
        if (cmd.rd_entry)
        begin
            ent_reg <= mem[idx_reg[IDX_W-1:0]];
        end
        if (cmd.chk_entry)
        begin
            hit_reg <= overlap;
        end
        if (cmd.store)
        begin
            mem[count_reg[IDX_W-1:0]] <= {x_reg[PW-1:0], y_reg[PW-1:0], w_reg, h_reg};
        end
    end

    arp_gcd u_gcd_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.gcd_start),
        .a      (step_x_reg),
        .b      (w_reg),
        .busy   (gx_busy),
        .result (gx_res)
    );

    arp_gcd u_gcd_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.gcd_start),
        .a      (step_y_reg),
        .b      (h_reg),
        .busy   (gy_busy),
        .result (gy_res)
    );

    assign sts.too_big      = (w_reg == '0) || (h_reg == '0) || (w_reg > eff_reg)
                            || (h_reg > eff_reg);
    assign sts.full         = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign sts.empty        = (count_reg == '0);
    assign sts.entries_done = (idx_reg >= count_reg);
    assign sts.hit          = hit_reg;
    assign sts.x_over       = x_reg > {1'b0, eff_reg - w_reg};
    assign sts.y_over       = y_reg > {1'b0, eff_reg - h_reg};
    assign sts.jump_busy    = jump_busy_reg || cmd.jump_x;
    assign sts.gcd_busy     = g_pend_reg || cmd.gcd_start;

    assign cand_x = x_reg[PW-1:0];
    assign cand_y = y_reg[PW-1:0];
endmodule

// ===== design/arp_ctrl.sv =====
// ----------------------------------------------------------------------------
// arp_ctrl: placement sequencer
// Steps the grid scan, entry checks, store and step update for one request.
// ----------------------------------------------------------------------------
module arp_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  arp_pkg::dp_sts_t          sts,
    input  logic [arp_pkg::POS_W-1:0] cand_x,
    input  logic [arp_pkg::POS_W-1:0] cand_y,
    output arp_pkg::dp_cmd_t          cmd,
    output logic [1:0]                status,
    output logic [arp_pkg::POS_W-1:0] offset_x,
    output logic [arp_pkg::POS_W-1:0] offset_y
);
    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_POS, S_READ, S_CMP, S_EVAL, S_JUMP, S_GCD, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg;
    logic [1:0] status_reg, status_next;
    logic [arp_pkg::POS_W-1:0] ox_reg, oy_reg, ox_next, oy_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        status_next = status_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ox_next = '0;
                oy_next = '0;
                priority if (sts.too_big)
                begin
                    status_next = arp_pkg::ST_TOO_BIG;
                    state_next  = S_OUT;
                end
                else if (sts.full)
                begin
                    status_next = arp_pkg::ST_FULL;
                    state_next  = S_OUT;
                end
                else if (sts.empty)
                begin
                    cmd.store   = 1'b1;
                    cmd.first   = 1'b1;
                    status_next = arp_pkg::ST_PLACED;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                priority if (sts.y_over)
                begin
                    status_next = arp_pkg::ST_NO_SPACE;
                    state_next  = S_OUT;
                end
                else if (sts.x_over)
                begin
                    cmd.next_row = 1'b1;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.entries_done)
                begin
                    cmd.store   = 1'b1;
                    cmd.gcd_start = 1'b1;
                    status_next = arp_pkg::ST_PLACED;
                    ox_next     = cand_x;
                    oy_next     = cand_y;
                    state_next  = S_GCD;
                end
                else
                begin
                    cmd.rd_entry = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.chk_entry = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.hit)
                begin
                    cmd.jump_x = 1'b1;
                    state_next = S_JUMP;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_JUMP:
            begin
                if (!sts.jump_busy)
                begin
                    state_next = S_POS;
                end
            end
            S_GCD:
            begin
                if (!sts.gcd_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            ox_reg     <= ox_next;
            oy_reg     <= oy_next;
            if (state_reg == S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign offset_x  = ox_reg;
    assign offset_y  = oy_reg;
endmodule

// ===== design/atlas_rect_placer_top.sv =====
// ----------------------------------------------------------------------------
// atlas_rect_placer_top: grid-scan rectangle placer for a square atlas
// Finds the first free grid position for each requested rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) carries rect_width and rect_height.
//   out channel (out_valid/out_ready) returns status, offset_x, offset_y,
//   one result per request. cfg_we/cfg_wdata set the atlas edge length.
// Sequence: a rejected or first request goes from the check state
//   straight to the output state; otherwise the scan steps through
//   candidate positions, reads, compares and evaluates each stored
//   rectangle at each position, steps x past each hit rectangle, and
//   ends with the gcd step update. The entry-check loop over the
//   rectangle memory sets the rate; one request is in work at a time.
// Reset: table empty, steps one, atlas size 4096; no clearing pass.
// Stall: a result waits in the output register until out_ready; the
//   next request is not taken until it is transferred.
// ----------------------------------------------------------------------------
module atlas_rect_placer_top #(
    parameter int MAX_ENTRIES = arp_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [arp_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [arp_pkg::SIZE_W-1:0] rect_width,
    input  logic [arp_pkg::SIZE_W-1:0] rect_height,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [arp_pkg::POS_W-1:0]  offset_x,
    output logic [arp_pkg::POS_W-1:0]  offset_y
);
    arp_pkg::dp_cmd_t cmd;
    arp_pkg::dp_sts_t sts;
    logic [arp_pkg::POS_W-1:0] cand_x, cand_y;

    arp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cand_x    (cand_x),
        .cand_y    (cand_y),
        .cmd       (cmd),
        .status    (status),
        .offset_x  (offset_x),
        .offset_y  (offset_y)
    );

    arp_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .cmd         (cmd),
        .sts         (sts),
        .cand_x      (cand_x),
        .cand_y      (cand_y)
    );
endmodule

// ===== design/arp_checker.sv =====
// ----------------------------------------------------------------------------
// arp_checker: port-level checks for the atlas rectangle placer
// Watches handshakes and result fields on the top level.
// ----------------------------------------------------------------------------
module arp_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                status,
    input logic [arp_pkg::POS_W-1:0] offset_x,
    input logic [arp_pkg::POS_W-1:0] offset_y
);
    // stalled result keeps valid, status and offset_x
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset_x))
        else $error("result changed under stall");

    // a request is never taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // failed requests report zero offsets
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != arp_pkg::ST_PLACED |-> offset_x == '0 && offset_y == '0)
        else $error("offset nonzero on failure");

    // an accepted request cannot produce a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");
endmodule

bind atlas_rect_placer_top arp_checker u_arp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .offset_x  (offset_x),
    .offset_y  (offset_y)
);
